// ----- rtl/core/ssi_pkg.sv -----
// Shared types and constants for the sorted set insert unit.
package ssi_pkg;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;
    localparam int POS_W   = 6;

    typedef enum logic [0:0] {
        OP_ADD  = 1'b0,
        OP_READ = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_ADDED = 3'd0,
        ST_DUP   = 3'd1,
        ST_FULL  = 3'd2,
        ST_READ  = 3'd3,
        ST_RANGE = 3'd4
    } status_t;

    typedef struct packed {
        status_t                     status;
        logic [COUNT_W-1:0]          count;
        logic [POS_W-1:0]            position;
        logic signed [VALUE_W-1:0]   read_value;
    } res_t;

endpackage

// ----- rtl/core/ssi_cell.sv -----
// One storage cell of the sorted chain: compare, shift-in and read gating.
module ssi_cell (
    input  logic                               clk,
    input  logic signed [ssi_pkg::VALUE_W-1:0] value,
    input  logic signed [ssi_pkg::VALUE_W-1:0] elem_prev,
    input  logic                               lt_prev,
    input  logic                               occupied,
    input  logic                               shift_en,
    input  logic                               rd_sel,
    output logic                               lt,
    output logic                               eq,
    output logic                               boundary,
    output logic signed [ssi_pkg::VALUE_W-1:0] elem,
    output logic signed [ssi_pkg::VALUE_W-1:0] rd_data
);
    import ssi_pkg::*;

    logic signed [VALUE_W-1:0] elem_reg;
    logic signed [VALUE_W-1:0] elem_next;

    assign lt       = occupied && (elem_reg < value);
    assign eq       = occupied && (elem_reg == value);
    assign boundary = lt_prev && !lt;
    assign elem     = elem_reg;
    assign rd_data  = rd_sel ? elem_reg : '0;

    // lower cells keep, boundary takes the new value, upper cells take the neighbor
    always_comb
    begin
        elem_next = elem_reg;
        if (shift_en && !lt)
        begin
            elem_next = lt_prev ? value : elem_prev;
        end
    end

    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
    end

endmodule

// ----- rtl/core/ssi_result_queue.sv -----
// Two-entry result buffer between the cell row and the output port.
module ssi_result_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ssi_pkg::res_t push_data,
    output logic          ready,
    output logic          valid,
    input  logic          pop_ready,
    output ssi_pkg::res_t head
);
    import ssi_pkg::*;

    res_t        head_reg;
    res_t        head_next;
    res_t        tail_reg;
    res_t        tail_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    logic        pop;

    assign valid = (fill_reg != 2'd0);
    assign ready = (fill_reg != 2'd2);
    assign head  = head_reg;
    assign pop   = valid && pop_ready;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        case ({push, pop})
            2'b10:
            begin
                if (fill_reg == 2'd0)
                begin
                    head_next = push_data;
                end
                else
                begin
                    tail_next = push_data;
                end
                fill_next = fill_reg + 2'd1;
            end
            2'b01:
            begin
                head_next = tail_reg;
                fill_next = fill_reg - 2'd1;
            end
            2'b11:
            begin
                if (fill_reg == 2'd1)
                begin
                    head_next = push_data;
                end
                else
                begin
                    head_next = tail_reg;
                    tail_next = push_data;
                end
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

// ----- rtl/core/sorted_set_insert_unit.sv -----
// Sorted set insert unit: a row of compare-and-shift cells holding distinct values in order.
// Results are registered in the result buffer and leave it in the order the requests were accepted.
// Throughput: one request per cycle while the result buffer has room; every cell compares and shifts in the same cycle.
// A two-entry result buffer keeps requests flowing while one result waits.
// Reset empties the set and the result buffer; cell contents are undefined until written.
module sorted_set_insert_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ssi_pkg::opcode_t                   opcode,
    input  logic signed [ssi_pkg::VALUE_W-1:0] value,
    input  logic [ssi_pkg::INDEX_W-1:0]        index,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ssi_pkg::status_t                   status,
    output logic [ssi_pkg::COUNT_W-1:0]        count,
    output logic [ssi_pkg::POS_W-1:0]          position,
    output logic signed [ssi_pkg::VALUE_W-1:0] read_value
);
    import ssi_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int RD_CELLS = 2 ** INDEX_W;

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;

    logic [CAPACITY-1:0]       lt;
    logic [CAPACITY-1:0]       eq;
    logic [CAPACITY-1:0]       boundary;
    logic [CAPACITY-1:0]       occupied;
    logic [CAPACITY-1:0]       rd_sel;
    logic signed [VALUE_W-1:0] elem    [CAPACITY];
    logic signed [VALUE_W-1:0] rd_data [CAPACITY];

    logic                      accept;
    logic                      found;
    logic                      full;
    logic                      insert;
    logic                      rd_ok;
    logic [IW-1:0]             pos_enc;
    logic signed [VALUE_W-1:0] rd_word;
    logic [IW+POS_W-1:0]       pos_ext;
    logic [CW+COUNT_W-1:0]     cnt_ext;
    logic [CW+INDEX_W-1:0]     idx_cmp;
    logic [CW+INDEX_W-1:0]     cnt_cmp;
    res_t                      res;
    res_t                      head;

    assign accept = in_valid && in_ready;
    assign found  = |eq;
    assign full   = (count_reg == CW'(CAPACITY));
    assign insert = accept && (opcode == OP_ADD) && !found && !full;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                      lt_prev;
            logic signed [VALUE_W-1:0] elem_prev;

            assign occupied[i] = (CW'(i) < count_reg);

            if (i == 0)
            begin : g_first
                assign lt_prev   = 1'b1;
                assign elem_prev = value;
            end
            else
            begin : g_rest
                assign lt_prev   = lt[i-1];
                assign elem_prev = elem[i-1];
            end

            if (i < RD_CELLS)
            begin : g_rd
                assign rd_sel[i] = (index == INDEX_W'(i));
            end
            else
            begin : g_nord
                assign rd_sel[i] = 1'b0;
            end

            ssi_cell u_cell (
                .clk       (clk),
                .value     (value),
                .elem_prev (elem_prev),
                .lt_prev   (lt_prev),
                .occupied  (occupied[i]),
                .shift_en  (insert),
                .rd_sel    (rd_sel[i]),
                .lt        (lt[i]),
                .eq        (eq[i]),
                .boundary  (boundary[i]),
                .elem      (elem[i]),
                .rd_data   (rd_data[i])
            );
        end
    endgenerate

    // boundary has at most one bit set: duplicate slot or insertion slot
    always_comb
    begin
        pos_enc = '0;
        rd_word = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (boundary[k])
            begin
                pos_enc = pos_enc | IW'(k);
            end
            rd_word = rd_word | rd_data[k];
        end
    end

    assign idx_cmp = {{CW{1'b0}}, index};
    assign cnt_cmp = {{INDEX_W{1'b0}}, count_reg};
    assign rd_ok   = (idx_cmp < cnt_cmp);

    assign count_next = insert ? (count_reg + CW'(1)) : count_reg;
    assign pos_ext    = {{POS_W{1'b0}}, pos_enc};
    assign cnt_ext    = {{COUNT_W{1'b0}}, count_next};

    always_comb
    begin
        res.count      = cnt_ext[COUNT_W-1:0];
        res.position   = '0;
        res.read_value = '0;
        if (opcode == OP_ADD)
        begin
            if (found)
            begin
                res.status   = ST_DUP;
                res.position = pos_ext[POS_W-1:0];
            end
            else if (full)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                res.status   = ST_ADDED;
                res.position = pos_ext[POS_W-1:0];
            end
        end
        else if (rd_ok)
        begin
            res.status     = ST_READ;
            res.read_value = rd_word;
        end
        else
        begin
            res.status = ST_RANGE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    ssi_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res),
        .ready     (in_ready),
        .valid     (out_valid),
        .pop_ready (out_ready),
        .head      (head)
    );

    assign status     = head.status;
    assign count      = head.count;
    assign position   = head.position;
    assign read_value = head.read_value;

endmodule

// ----- rtl/core/ssi_checker.sv -----
// Port-level checks for the sorted set insert unit, bound to the top level.
module ssi_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  ssi_pkg::status_t                   status,
    input  logic [ssi_pkg::COUNT_W-1:0]        count,
    input  logic [ssi_pkg::POS_W-1:0]          position,
    input  logic signed [ssi_pkg::VALUE_W-1:0] read_value
);
    import ssi_pkg::*;

    // back-pressure on input only when a result is pending
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no pending result");

    // an accepted request is always followed by a valid result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted request gave no result");

    a_no_position: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL || status == ST_RANGE || status == ST_READ))
        |-> (position == '0))
        else $error("position set on a result that has none");

    a_add_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_ADDED || status == ST_DUP || status == ST_FULL
                       || status == ST_RANGE)) |-> (read_value == '0))
        else $error("read data set on a result that has none");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(count)))
        else $error("stalled result changed");

endmodule

bind sorted_set_insert_unit ssi_checker u_ssi_checker (.*);

// ----- tb/sorted_set_insert_unit_tb.sv -----
// Testbench for the sorted set insert unit: directed and random add/read requests, self-checked.
module sorted_set_insert_unit_tb;
    import ssi_pkg::*;

    localparam int CAPACITY        = 64;
    localparam int RANDOM_ITEMS    = 440;
    localparam int HOLD_OFF_CYCLES = 48;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int DRAIN_CYCLES    = 4;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    opcode_t                   opcode;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;
    logic                      out_valid;
    logic                      out_ready;
    status_t                   status;
    logic [COUNT_W-1:0]        count;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] read_value;

    // mirror of the stored set
    logic signed [VALUE_W-1:0] mirror_elems [CAPACITY];
    int                        mirror_count;
    res_t                      awaited_results[$];

    int mismatch_count;
    int idle_cycles;
    int burst_left;
    int gap_max;
    bit hold_off_req;

    sorted_set_insert_unit #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .value     (value),
        .index     (index),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .count     (count),
        .position  (position),
        .read_value(read_value)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Expected result of one request; updates the mirror.
    function automatic res_t set_request_result(opcode_t op, logic signed [VALUE_W-1:0] v,
                                                logic [INDEX_W-1:0] idx);
        res_t r;
        int   slot;
        bit   found;
        r = '0;
        slot = 0;
        found = 1'b0;
        if (op == OP_ADD)
        begin
            for (int i = 0; i < mirror_count; i++)
            begin
                if (!found)
                begin
                    if (mirror_elems[i] == v)
                    begin
                        found = 1'b1;
                        slot = i;
                    end
                    else if (mirror_elems[i] < v)
                    begin
                        slot = i + 1;
                    end
                end
            end
            if (found)
            begin
                r.status = ST_DUP;
                r.position = slot[POS_W-1:0];
            end
            else if (mirror_count >= CAPACITY)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                for (int i = mirror_count; i > slot; i--)
                    mirror_elems[i] = mirror_elems[i-1];
                mirror_elems[slot] = v;
                mirror_count++;
                r.status = ST_ADDED;
                r.position = slot[POS_W-1:0];
            end
        end
        else
        begin
            if (int'(idx) < mirror_count)
            begin
                r.status = ST_READ;
                r.read_value = mirror_elems[idx];
            end
            else
            begin
                r.status = ST_RANGE;
            end
        end
        r.count = mirror_count[COUNT_W-1:0];
        return r;
    endfunction

    task automatic send_request(opcode_t op, logic signed [VALUE_W-1:0] v,
                                logic [INDEX_W-1:0] idx);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= v;
        index    <= idx;
        do @(posedge clk); while (!in_ready);
        awaited_results.push_back(set_request_result(op, v, idx));
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (awaited_results.size() != 0);
    endtask

    function automatic logic [INDEX_W-1:0] pick_read_index();
        if (mirror_count > 0 && $urandom_range(0, 3) != 0)
            return INDEX_W'($urandom_range(0, mirror_count - 1));
        return INDEX_W'($urandom_range(0, CAPACITY - 1));
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_add_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (mirror_count > 0 && pick >= 40 && pick < 65)
            return mirror_elems[$urandom_range(0, mirror_count - 1)];
        if (mirror_count > 0 && pick >= 65 && pick < 80)
            return mirror_elems[$urandom_range(0, mirror_count - 1)]
                   + ($urandom_range(0, 1) ? 1 : -1);
        if (pick >= 80)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic test_empty_reads();
        send_request(OP_READ, 32'sd0, 6'd0);
        send_request(OP_READ, -32'sd1, 6'd63);
        send_request(OP_READ, 32'sh5555_5555, 6'd42);
    endtask

    task automatic test_value_extremes();
        send_request(OP_ADD, 32'sd0, 6'd63);
        send_request(OP_ADD, 32'sh8000_0000, 6'd0);
        send_request(OP_ADD, 32'sh7FFF_FFFF, 6'd21);
        send_request(OP_ADD, -32'sd1, 6'd0);
        send_request(OP_ADD, 32'sd1, 6'd0);
        send_request(OP_ADD, 32'sh8000_0000, 6'd0);
        send_request(OP_ADD, 32'sh7FFF_FFFF, 6'd0);
        send_request(OP_ADD, 32'sd0, 6'd0);
        for (int i = 0; i < 6; i++)
            send_request(OP_READ, 32'shAAAA_AAAA, i[INDEX_W-1:0]);
        send_request(OP_READ, 32'sd0, 6'd63);
    endtask

    task automatic test_random_mix();
        gap_max = 6;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 120)
                hold_off_req = 1'b1;
            if (n == 200)
                gap_max = 0;
            if (n == 260)
                gap_max = 20;
            if (n == 320)
            begin
                wait_results_drained();
                gap_max = 6;
            end
            if ($urandom_range(0, 99) < 45)
                send_request(OP_READ, $urandom, pick_read_index());
            else
                send_request(OP_ADD, pick_add_value(), INDEX_W'($urandom));
        end
    endtask

    task automatic test_full_store();
        while (mirror_count < CAPACITY)
            send_request(OP_ADD, $urandom, INDEX_W'($urandom));
        send_request(OP_ADD, $urandom, INDEX_W'($urandom));
        send_request(OP_ADD, mirror_elems[0], INDEX_W'($urandom));
        send_request(OP_ADD, mirror_elems[CAPACITY-1], INDEX_W'($urandom));
        send_request(OP_ADD, mirror_elems[CAPACITY/2], INDEX_W'($urandom));
        send_request(OP_READ, $urandom, 6'd63);
        send_request(OP_READ, $urandom, 6'd0);
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        opcode   <= OP_ADD;
        value    <= '0;
        index    <= '0;
        mismatch_count = 0;
        mirror_count = 0;
        burst_left = 0;
        gap_max = 6;
        hold_off_req = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_reads();
        test_value_extremes();
        test_random_mix();
        test_full_store();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("sorted_set_insert_unit verification clean");
        else
            $display("sorted_set_insert_unit verification failed");
        $finish;
    end

    // result receiver: random stall pattern, plus one long hold-off on request
    initial
    begin
        logic [15:0] stall_pattern;
        int          rx_tick;
        out_ready <= 1'b0;
        stall_pattern = 16'hFFFF;
        rx_tick = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                if (rx_tick % 32 == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: stall_pattern = 16'hFFFF;
                        1: stall_pattern = 16'($urandom & $urandom);
                        default: stall_pattern = 16'($urandom);
                    endcase
                end
                out_ready <= stall_pattern[rx_tick % 16];
                rx_tick++;
            end
        end
    end

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result, status %0d count %0d", $time, status,
                             count);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("count", 32'(want.count), 32'(count));
                    check_field("position", 32'(want.position), 32'(position));
                    check_field("read_value", want.read_value, read_value);
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("sorted_set_insert_unit verification failed");
                $finish;
            end
        end
        else
        begin
            idle_cycles = 0;
        end
    end

endmodule
